[hw/rtl/bmha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmha_pkg
// Shared types and constants of the block map heap allocator.
// ----------------------------------------------------------------------------
package bmha_pkg;

   localparam int KIND_W     = 2;
   localparam int OFF_W      = 20;
   localparam int SZ_W       = 21;
   localparam int ST_W       = 2;
   localparam int RB_W       = 9;
   localparam int FB_W       = 21;
   localparam int BS_W       = 13;
   localparam int NB_W       = 9;
   localparam int DIV_W      = 22;
   localparam int REM_W      = 13;
   localparam int FR_W       = 10;
   localparam int PROD_W     = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESIZE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_VALIDATE = 2'd3;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
   localparam logic [ST_W-1:0] ST_BADPTR  = 2'd2;
   localparam logic [ST_W-1:0] ST_NOHEAD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_BLOCKS = 2'd1;

   localparam logic [BS_W-1:0] BS_MIN   = 13'd4;
   localparam logic [BS_W-1:0] BS_MAX   = 13'd4096;
   localparam logic [BS_W-1:0] BS_RESET = 13'd64;
   localparam logic [NB_W-1:0] NB_MIN   = 9'd1;
   localparam logic [NB_W-1:0] NB_RESET = 9'd256;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_TOTAL,
      OP_CLEAR,
      OP_DIV_SIZE,
      OP_DIV_OFF,
      OP_DIV_STEP,
      OP_ALLOC_INIT,
      OP_ALLOC_SCAN,
      OP_ALLOC_HEAD,
      OP_FILL,
      OP_REL_FREE,
      OP_REL_MOVE,
      OP_ST_OOM,
      OP_ST_BAD,
      OP_ST_NOHEAD,
      OP_LOC_READ,
      OP_LOC_HEAD,
      OP_LOC_SCAN,
      OP_VALIDATE,
      OP_LEN_PROD,
      OP_KEEP,
      OP_GROW_INIT,
      OP_GROW_SCAN,
      OP_GROW_HEAD,
      OP_FB_MUL,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_A_CLR,
      S_DIVA,
      S_ASCAN,
      S_AHEAD,
      S_AFILL,
      S_AREL,
      S_FILL,
      S_OOM,
      S_BAD,
      S_LOC,
      S_DIVO,
      S_LHEAD,
      S_LSCAN,
      S_LDONE,
      S_RCHK,
      S_DIVG,
      S_GSCAN,
      S_AINIT,
      S_GHEAD,
      S_FB,
      S_EMIT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              has_ptr;
      logic              used_zero;
      logic              off_oob;
      logic              div_done;
      logic              scan_end;
      logic              hit;
      logic              no_head;
      logic              loc_end;
      logic              fits;
      logic              gfail;
      logic              ghit;
      logic              fill_done;
   } dp_sts_type;

endpackage

[hw/rtl/bmha_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmha_if
// Request, response and register write channels of the allocator.
// ----------------------------------------------------------------------------
interface bmha_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmha_pkg::KIND_W-1:0] kind;
   logic                        has_pointer;
   logic [bmha_pkg::OFF_W-1:0]  byte_offset;
   logic [bmha_pkg::SZ_W-1:0]   size_bytes;

   modport source (output valid, kind, has_pointer, byte_offset, size_bytes, input ready);
   modport sink   (input valid, kind, has_pointer, byte_offset, size_bytes, output ready);
endinterface

interface bmha_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bmha_pkg::ST_W-1:0]   status;
   logic                        result_valid;
   logic [bmha_pkg::OFF_W-1:0]  result_offset;
   logic [bmha_pkg::RB_W-1:0]   run_blocks;
   logic                        moved;
   logic [bmha_pkg::FB_W-1:0]   free_bytes;

   modport source (output valid, status, result_valid, result_offset, run_blocks, moved,
                   free_bytes, input ready);
   modport sink   (input valid, status, result_valid, result_offset, run_blocks, moved,
                   free_bytes, output ready);
endinterface

interface bmha_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bmha_pkg::CSR_IDX_W-1:0]  index;
   logic [bmha_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/bmha_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmha_dp
// Datapath: block map memory, divider, scan counters, run writer, results.
// ----------------------------------------------------------------------------
module bmha_dp #(
   parameter int MAP_DEPTH  = 256,
   parameter int ENTRY_BITS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bmha_pkg::dp_cmd_type          cmd,
   output bmha_pkg::dp_sts_type          sts,
   input  logic [bmha_pkg::KIND_W-1:0]   req_kind,
   input  logic                          req_has_pointer,
   input  logic [bmha_pkg::OFF_W-1:0]    req_byte_offset,
   input  logic [bmha_pkg::SZ_W-1:0]     req_size_bytes,
   input  logic [bmha_pkg::BS_W-1:0]     eff_bs,
   input  logic [bmha_pkg::NB_W-1:0]     eff_n,
   output logic [bmha_pkg::ST_W-1:0]     rsp_status,
   output logic                          rsp_result_valid,
   output logic [bmha_pkg::OFF_W-1:0]    rsp_result_offset,
   output logic [bmha_pkg::RB_W-1:0]     rsp_run_blocks,
   output logic                          rsp_moved,
   output logic [bmha_pkg::FB_W-1:0]     rsp_free_bytes
);
   import bmha_pkg::*;

   localparam int IDX_W    = $clog2(MAP_DEPTH);
   localparam int CNT_BASE = (IDX_W + 1 > NB_W) ? IDX_W + 1 : NB_W;
   localparam int CNT_W    = ((CNT_BASE > ENTRY_BITS) ? CNT_BASE : ENTRY_BITS) + 1;
   localparam int MUL_W    = IDX_W + BS_W;
   localparam int DCNT_W   = $clog2(DIV_W + 1);
   localparam logic [ENTRY_BITS-1:0] CONT = '1;

   // request word
   logic [KIND_W-1:0] kind_ff;
   logic              hp_ff;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [SZ_W-1:0]   size_ff;
   // products
   logic [PROD_W-1:0] total_ff, total_in, prod_ff, prod_in;
   // divider
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dq_ff, dq_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [REM_W:0]    div_t;
   logic              div_ge;
   // scan state
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [FR_W-1:0]   fr_ff, fr_in, fr_nx;
   logic [IDX_W-1:0]  idx_ff, idx_in, s_ff, s_in;
   logic [RB_W-1:0]   len_ff, len_in;
   logic [DIV_W-1:0]  blks_ff, blks_in, need_ff, need_in;
   // run writer
   logic [CNT_W-1:0]  wp_ff, wp_in;
   logic [RB_W-1:0]   wn_ff, wn_in;
   logic              wv_ff, wv_in;
   logic [NB_W-1:0]   used_ff, used_in;
   logic [NB_W:0]     used_sum;
   logic [RB_W-1:0]   used_delta;
   logic              used_add, used_sub;
   // results
   logic [ST_W-1:0]   st_ff, st_in;
   logic              val_ff, val_in, mv_ff, mv_in;
   logic [OFF_W-1:0]  roff_ff, roff_in;
   logic [RB_W-1:0]   rb_ff, rb_in;
   logic [RB_W-1:0]   grow_len;
   // memory
   logic [ENTRY_BITS-1:0] map_mem [MAP_DEPTH];
   logic [MAP_DEPTH-1:0]  vld_ff;
   logic [ENTRY_BITS-1:0] mem_q, wr_data, ent;
   logic                  vld_q, wr_en, clr;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [CNT_W-1:0]      n_c;
   logic                  c_lt_n, ent_free, ent_cont, hit, gfail, ghit, loc_end;

   assign ent      = vld_q ? mem_q : '0;
   assign ent_free = (ent == '0);
   assign ent_cont = (ent == CONT);
   assign n_c      = CNT_W'(eff_n);
   assign c_lt_n   = (c_ff < n_c);
   assign fr_nx    = fr_ff + FR_W'(1);
   assign hit      = ent_free && (DIV_W'(fr_nx) == blks_ff);
   assign gfail    = !c_lt_n || !ent_free;
   assign ghit     = !gfail && (DIV_W'(fr_nx) == need_ff);
   assign loc_end  = !(c_lt_n && ent_cont);
   assign grow_len = len_ff + need_ff[RB_W-1:0];

   assign div_t  = {rem_ff, dq_ff[DIV_W-1]};
   assign div_ge = (div_t >= {1'b0, eff_bs});

   assign used_sum = {1'b0, used_ff} + (NB_W + 1)'(used_delta);

   always_comb begin
      sts.kind      = kind_ff;
      sts.has_ptr   = hp_ff;
      sts.used_zero = (used_ff == '0);
      sts.off_oob   = (PROD_W'(off_ff) >= total_ff);
      sts.div_done  = (dcnt_ff == '0);
      sts.scan_end  = !c_lt_n || (blks_ff == '0);
      sts.hit       = hit;
      sts.no_head   = ent_free || ent_cont;
      sts.loc_end   = loc_end;
      sts.fits      = (PROD_W'(size_ff) <= prod_ff);
      sts.gfail     = gfail;
      sts.ghit      = ghit;
      sts.fill_done = (wn_ff == '0);
   end

   always_comb begin
      off_in     = off_ff;
      total_in   = total_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      dcnt_in    = dcnt_ff;
      c_in       = c_ff;
      fr_in      = fr_ff;
      idx_in     = idx_ff;
      s_in       = s_ff;
      len_in     = len_ff;
      blks_in    = blks_ff;
      need_in    = need_ff;
      wp_in      = wp_ff;
      wn_in      = wn_ff;
      wv_in      = wv_ff;
      st_in      = st_ff;
      val_in     = val_ff;
      mv_in      = mv_ff;
      roff_in    = roff_ff;
      rb_in      = rb_ff;
      used_add   = 1'b0;
      used_sub   = 1'b0;
      used_delta = '0;
      wr_en      = 1'b0;
      wr_addr    = wp_ff[IDX_W-1:0];
      wr_data    = '0;
      clr        = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            off_in  = req_byte_offset;
            st_in   = ST_OK;
            val_in  = 1'b0;
            mv_in   = 1'b0;
            roff_in = '0;
            rb_in   = '0;
         end
         OP_TOTAL:    total_in = PROD_W'(eff_n) * PROD_W'(eff_bs);
         OP_CLEAR:    clr = 1'b1;
         OP_DIV_SIZE: begin
            dq_in   = DIV_W'(size_ff) + DIV_W'(eff_bs) - DIV_W'(1);
            rem_in  = '0;
            dcnt_in = DCNT_W'(DIV_W);
         end
         OP_DIV_OFF: begin
            dq_in   = DIV_W'(off_ff);
            rem_in  = '0;
            dcnt_in = DCNT_W'(DIV_W);
         end
         OP_DIV_STEP: begin
            if (dcnt_ff != '0) begin
               rem_in  = div_ge ? REM_W'(div_t - {1'b0, eff_bs}) : div_t[REM_W-1:0];
               dq_in   = {dq_ff[DIV_W-2:0], div_ge};
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end
         end
         OP_ALLOC_INIT: begin
            blks_in = dq_ff;
            c_in    = '0;
            fr_in   = '0;
         end
         OP_ALLOC_SCAN: begin
            if (c_lt_n && (blks_ff != '0)) begin
               if (ent_free) begin
                  if (hit) begin
                     s_in = IDX_W'(DIV_W'(c_ff) - blks_ff + DIV_W'(1));
                  end else begin
                     c_in  = c_ff + CNT_W'(1);
                     fr_in = fr_nx;
                  end
               end else if (ent_cont) begin
                  c_in  = c_ff + CNT_W'(1);
                  fr_in = '0;
               end else begin
                  // skip the whole run from its head
                  c_in  = c_ff + CNT_W'(ent);
                  fr_in = '0;
               end
            end
         end
         OP_ALLOC_HEAD: begin
            wr_en      = 1'b1;
            wr_addr    = s_ff;
            wr_data    = ENTRY_BITS'(blks_ff);
            used_add   = 1'b1;
            used_delta = blks_ff[RB_W-1:0];
            val_in     = 1'b1;
            roff_in    = OFF_W'(MUL_W'(s_ff) * MUL_W'(eff_bs));
            rb_in      = blks_ff[RB_W-1:0];
            wp_in      = CNT_W'(s_ff) + CNT_W'(1);
            wn_in      = blks_ff[RB_W-1:0] - RB_W'(1);
            wv_in      = 1'b1;
         end
         OP_FILL: begin
            if (wn_ff != '0) begin
               wr_en   = (wp_ff < CNT_W'(MAP_DEPTH));
               wr_data = wv_ff ? CONT : '0;
               wp_in   = wp_ff + CNT_W'(1);
               wn_in   = wn_ff - RB_W'(1);
            end
         end
         OP_REL_FREE, OP_REL_MOVE: begin
            wp_in      = CNT_W'(idx_ff);
            wn_in      = len_ff;
            wv_in      = 1'b0;
            used_sub   = 1'b1;
            used_delta = len_ff;
            if (cmd.op == OP_REL_FREE) begin
               rb_in = len_ff;
            end else begin
               mv_in = 1'b1;
            end
         end
         OP_ST_OOM:    st_in = ST_NOMEM;
         OP_ST_BAD:    st_in = ST_BADPTR;
         OP_ST_NOHEAD: st_in = ST_NOHEAD;
         OP_LOC_READ:  idx_in = dq_ff[IDX_W-1:0];
         OP_LOC_HEAD:  c_in = CNT_W'(idx_ff) + CNT_W'(1);
         OP_LOC_SCAN: begin
            if (loc_end) begin
               len_in = RB_W'(c_ff - CNT_W'(idx_ff));
            end else begin
               c_in = c_ff + CNT_W'(1);
            end
         end
         OP_VALIDATE: begin
            val_in  = 1'b1;
            roff_in = OFF_W'(MUL_W'(idx_ff) * MUL_W'(eff_bs));
            rb_in   = len_ff;
         end
         OP_LEN_PROD: prod_in = PROD_W'(len_ff) * PROD_W'(eff_bs);
         OP_KEEP: begin
            val_in  = 1'b1;
            roff_in = off_ff;
            rb_in   = len_ff;
         end
         OP_GROW_INIT: begin
            blks_in = dq_ff;
            need_in = dq_ff - DIV_W'(len_ff);
            c_in    = CNT_W'(idx_ff) + CNT_W'(len_ff);
            fr_in   = '0;
         end
         OP_GROW_SCAN: begin
            if (!gfail && !ghit) begin
               c_in  = c_ff + CNT_W'(1);
               fr_in = fr_nx;
            end
         end
         OP_GROW_HEAD: begin
            wr_en      = 1'b1;
            wr_addr    = idx_ff;
            wr_data    = ENTRY_BITS'(grow_len);
            used_add   = 1'b1;
            used_delta = need_ff[RB_W-1:0];
            val_in     = 1'b1;
            roff_in    = off_ff;
            rb_in      = grow_len;
            wp_in      = CNT_W'(idx_ff) + CNT_W'(len_ff);
            wn_in      = need_ff[RB_W-1:0];
            wv_in      = 1'b1;
         end
         OP_FB_MUL: prod_in = PROD_W'(used_ff) * PROD_W'(eff_bs);
         default: begin
         end
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (used_add) begin
         used_in = used_sum[NB_W] ? '1 : used_sum[NB_W-1:0];
      end else if (used_sub) begin
         used_in = (NB_W'(used_delta) > used_ff) ? '0 : used_ff - NB_W'(used_delta);
      end
   end

   // scans look one entry ahead: the read address follows the next counter value
   assign rd_addr = (cmd.op == OP_LOC_READ) ? dq_ff[IDX_W-1:0] : c_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      mem_q <= map_mem[rd_addr];
      vld_q <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
         wn_ff   <= '0;
         used_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
         wn_ff   <= wn_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         kind_ff <= req_kind;
         hp_ff   <= req_has_pointer;
         size_ff <= req_size_bytes;
      end
      off_ff   <= off_in;
      total_ff <= total_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      c_ff     <= c_in;
      fr_ff    <= fr_in;
      idx_ff   <= idx_in;
      s_ff     <= s_in;
      len_ff   <= len_in;
      blks_ff  <= blks_in;
      need_ff  <= need_in;
      wp_ff    <= wp_in;
      wv_ff    <= wv_in;
      st_ff    <= st_in;
      val_ff   <= val_in;
      mv_ff    <= mv_in;
      roff_ff  <= roff_in;
      rb_ff    <= rb_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_status        <= st_ff;
         rsp_result_valid  <= val_ff;
         rsp_result_offset <= roff_ff;
         rsp_run_blocks    <= rb_ff;
         rsp_moved         <= mv_ff;
         rsp_free_bytes    <= (prod_ff >= total_ff) ? '0 : FB_W'(total_ff - prod_ff);
      end
   end

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP && dcnt_ff != '0) |=> dcnt_ff == $past(dcnt_ff) - DCNT_W'(1))
      else $error("divider step count did not advance");

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOC_SCAN && loc_end) |=> len_ff != '0)
      else $error("located run has zero length");

   a_alloc_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ALLOC_SCAN && !sts.scan_end && hit) |=> (CNT_W'(s_ff) < n_c))
      else $error("allocated run starts outside the map");

endmodule

[hw/rtl/bmha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmha_ctrl
// Request sequencer: steps the datapath through each request and emits.
// ----------------------------------------------------------------------------
module bmha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bmha_pkg::dp_sts_type sts,
   output bmha_pkg::dp_cmd_type cmd
);
   import bmha_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free, alloc_path;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign alloc_path = (sts.kind == KIND_ALLOC) || (sts.kind == KIND_RESIZE && !sts.has_ptr);
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.op = OP_TOTAL;
            if (alloc_path) begin
               state_in = S_A_CLR;
            end else if (!sts.has_ptr) begin
               state_in = (sts.kind == KIND_FREE) ? S_FB : S_BAD;
            end else begin
               state_in = S_LOC;
            end
         end
         S_A_CLR: begin
            // an empty heap starts from a clean map; the divider is loaded next
            cmd.op   = sts.used_zero ? OP_CLEAR : OP_NONE;
            state_in = S_AINIT;
         end
         S_AINIT: begin
            if (sts.kind == KIND_RESIZE && sts.has_ptr) begin
               cmd.op   = OP_ALLOC_INIT;
               state_in = S_ASCAN;
            end else begin
               cmd.op   = OP_DIV_SIZE;
               state_in = S_DIVA;
            end
         end
         S_DIVA: begin
            if (sts.div_done) begin
               cmd.op   = OP_ALLOC_INIT;
               state_in = S_ASCAN;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_ASCAN: begin
            cmd.op = OP_ALLOC_SCAN;
            if (sts.scan_end) begin
               state_in = S_OOM;
            end else if (sts.hit) begin
               state_in = S_AHEAD;
            end
         end
         S_AHEAD: begin
            cmd.op   = OP_ALLOC_HEAD;
            state_in = S_AFILL;
         end
         S_AFILL: begin
            cmd.op = OP_FILL;
            if (sts.fill_done) begin
               state_in = (sts.kind == KIND_RESIZE && sts.has_ptr) ? S_AREL : S_FB;
            end
         end
         S_AREL: begin
            cmd.op   = OP_REL_MOVE;
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd.op = OP_FILL;
            if (sts.fill_done) begin
               state_in = S_FB;
            end
         end
         S_OOM: begin
            cmd.op   = OP_ST_OOM;
            state_in = S_FB;
         end
         S_BAD: begin
            cmd.op   = OP_ST_BAD;
            state_in = S_FB;
         end
         S_LOC: begin
            if (sts.used_zero || sts.off_oob) begin
               cmd.op   = OP_ST_BAD;
               state_in = S_FB;
            end else begin
               cmd.op   = OP_DIV_OFF;
               state_in = S_DIVO;
            end
         end
         S_DIVO: begin
            if (sts.div_done) begin
               cmd.op   = OP_LOC_READ;
               state_in = S_LHEAD;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_LHEAD: begin
            if (sts.no_head) begin
               cmd.op   = OP_ST_NOHEAD;
               state_in = S_FB;
            end else begin
               cmd.op   = OP_LOC_HEAD;
               state_in = S_LSCAN;
            end
         end
         S_LSCAN: begin
            cmd.op = OP_LOC_SCAN;
            if (sts.loc_end) begin
               state_in = S_LDONE;
            end
         end
         S_LDONE: begin
            case (sts.kind)
               KIND_FREE: begin
                  cmd.op   = OP_REL_FREE;
                  state_in = S_FILL;
               end
               KIND_RESIZE: begin
                  cmd.op   = OP_LEN_PROD;
                  state_in = S_RCHK;
               end
               default: begin
                  cmd.op   = OP_VALIDATE;
                  state_in = S_FB;
               end
            endcase
         end
         S_RCHK: begin
            if (sts.fits) begin
               cmd.op   = OP_KEEP;
               state_in = S_FB;
            end else begin
               cmd.op   = OP_DIV_SIZE;
               state_in = S_DIVG;
            end
         end
         S_DIVG: begin
            if (sts.div_done) begin
               cmd.op   = OP_GROW_INIT;
               state_in = S_GSCAN;
            end else begin
               cmd.op = OP_DIV_STEP;
            end
         end
         S_GSCAN: begin
            cmd.op = OP_GROW_SCAN;
            if (sts.gfail) begin
               state_in = S_AINIT;   // no room in place: first-fit a new run
            end else if (sts.ghit) begin
               state_in = S_GHEAD;
            end
         end
         S_GHEAD: begin
            cmd.op   = OP_GROW_HEAD;
            state_in = S_FILL;
         end
         S_FB: begin
            cmd.op   = OP_FB_MUL;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("response raised outside the emit step");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> sts.div_done)
      else $error("divider still busy while idle");

   a_fb_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FB) |-> sts.fill_done)
      else $error("map writes pending at free byte step");

endmodule

[hw/rtl/block_map_heap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_map_heap_allocator
// First-fit block heap allocator over a run-length block map.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken once the previous word
// has been placed in the response register. A request's run time grows with the
// divisions (the shared one-bit-per-cycle divider runs for the pointer and for
// the byte size, as the request needs them), with the map entries visited by a
// scan (the map memory is read once per cycle) and with the map entries written
// when a run is marked or released.
module block_map_heap_allocator #(
   parameter int MAP_DEPTH  = 256,
   parameter int ENTRY_BITS = 9
) (
   input  logic       clock,
   input  logic       reset,
   bmha_req_if.sink   req_ch,
   bmha_rsp_if.source rsp_ch,
   bmha_csr_if.sink   csr_ch
);
   import bmha_pkg::*;

   logic [BS_W-1:0] block_size_ff, block_size_in, eff_bs;
   logic [NB_W-1:0] num_blocks_ff, num_blocks_in, eff_n;
   dp_cmd_type      cmd;
   dp_sts_type      sts;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      block_size_in = block_size_ff;
      num_blocks_in = num_blocks_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_BLOCK_SIZE: block_size_in = csr_ch.data;
            REG_NUM_BLOCKS: num_blocks_in = csr_ch.data[NB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BS_RESET;
         num_blocks_ff <= NB_RESET;
      end else begin
         block_size_ff <= block_size_in;
         num_blocks_ff <= num_blocks_in;
      end
   end

   always_comb begin
      if (block_size_ff < BS_MIN) begin
         eff_bs = BS_MIN;
      end else if (block_size_ff > BS_MAX) begin
         eff_bs = BS_MAX;
      end else begin
         eff_bs = block_size_ff;
      end
      if (num_blocks_ff < NB_MIN) begin
         eff_n = NB_MIN;
      end else if (int'(num_blocks_ff) > MAP_DEPTH) begin
         eff_n = NB_W'(MAP_DEPTH);
      end else begin
         eff_n = num_blocks_ff;
      end
   end

   bmha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmha_dp #(
      .MAP_DEPTH  (MAP_DEPTH),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_ch.kind),
      .req_has_pointer   (req_ch.has_pointer),
      .req_byte_offset   (req_ch.byte_offset),
      .req_size_bytes    (req_ch.size_bytes),
      .eff_bs            (eff_bs),
      .eff_n             (eff_n),
      .rsp_status        (rsp_ch.status),
      .rsp_result_valid  (rsp_ch.result_valid),
      .rsp_result_offset (rsp_ch.result_offset),
      .rsp_run_blocks    (rsp_ch.run_blocks),
      .rsp_moved         (rsp_ch.moved),
      .rsp_free_bytes    (rsp_ch.free_bytes)
   );

endmodule
